// ===== design/ssw_pwm_pkg.sv =====
// Shared types and constants for the soft-switched PWM ramp block.
package ssw_pwm_pkg;

    // Switch mode codes as reported on the mode port
    typedef enum logic [1:0] {
        MODE_OFF         = 2'd0,
        MODE_TURNING_ON  = 2'd1,
        MODE_ON          = 2'd2,
        MODE_TURNING_OFF = 2'd3
    } switch_mode_t;

    // Configuration register indexes
    localparam logic [2:0] REG_ON_RAMP   = 3'd0;
    localparam logic [2:0] REG_OFF_RAMP  = 3'd1;
    localparam logic [2:0] REG_HOLD      = 3'd2;
    localparam logic [2:0] REG_OFF_LOW   = 3'd3;
    localparam logic [2:0] REG_OFF_HIGH  = 3'd4;

    // Request codes on func
    localparam logic FUNC_ON  = 1'b0;
    localparam logic FUNC_OFF = 1'b1;

    localparam int TIME_W  = 32;
    localparam int RAMP_W  = 16;
    localparam int DUTY_W  = 8;
    localparam int PROD_W  = RAMP_W + DUTY_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_ZERO = 8'd0;

endpackage

// ===== design/soft_switch_pwm_ramp.sv =====
// Soft-switched PWM output with linear turn-on and turn-off ramps.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, func, now_ms          | input item
//  out     | out_valid, out_ready, duty, mode          | result item
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// A step that lands in a ramp runs through a multiply state, then a shared
// compare/subtract unit that forms the 8-bit quotient one bit a cycle, then a
// state that posts it. A step that finishes or changes nothing goes straight
// from accept to the posting state.
// Reset: mode off, duty level 0, start times 0, registers at their reset values (duty and mode ports are not reset).
// in_ready is low while a step is in work; a result waiting on out_ready
// lets the next item be accepted, and only the posting cycle stalls.
module soft_switch_pwm_ramp
    import ssw_pwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DUTY_W-1:0]     duty,
    output logic [1:0]            mode,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                state_reg;
    switch_mode_t          switch_mode_reg;
    logic [TIME_W-1:0]     on_start_reg;
    logic [TIME_W-1:0]     off_start_reg;
    logic [DUTY_W-1:0]     duty_level_reg;

    // configuration
    logic [RAMP_W-1:0]     on_ramp_reg;
    logic [RAMP_W-1:0]     off_ramp_reg;
    logic [DUTY_W-1:0]     hold_reg;
    logic [DUTY_W-1:0]     off_low_reg;
    logic [DUTY_W-1:0]     off_high_reg;

    // ramp operands and divider state
    logic [RAMP_W-1:0]     rem_reg;
    logic [RAMP_W-1:0]     len_reg;
    logic [DUTY_W-1:0]     lo_reg;
    logic [DUTY_W-1:0]     span_mag_reg;
    logic                  span_neg_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     dvs_reg;
    logic [DUTY_W-1:0]     quot_reg;
    logic [2:0]            cnt_reg;

    logic                  out_valid_reg;
    logic [DUTY_W-1:0]     out_duty_reg;
    logic [1:0]            out_mode_reg;

    // ---------------------------------------------------------------
    // Step decision at accept
    // ---------------------------------------------------------------
    switch_mode_t          mode_next;
    logic [TIME_W-1:0]     on_start_next;
    logic [TIME_W-1:0]     off_start_next;
    logic [TIME_W-1:0]     elapsed;
    logic [RAMP_W-1:0]     len_sel;
    logic [TIME_W-1:0]     start_sel;
    logic                  ramp_go;
    logic                  settle;
    logic [DUTY_W-1:0]     settle_duty;
    logic [DUTY_W-1:0]     lo_sel;
    logic [DUTY_W:0]       span_sel;

    always_comb
    begin
        mode_next      = switch_mode_reg;
        on_start_next  = on_start_reg;
        off_start_next = off_start_reg;
        if (func == FUNC_ON) begin
            if (switch_mode_reg == MODE_OFF || switch_mode_reg == MODE_TURNING_OFF)
            begin
                mode_next     = MODE_TURNING_ON;
                on_start_next = now_ms;
            end
            start_sel   = on_start_next;
            len_sel     = on_ramp_reg;
            lo_sel      = hold_reg;
            span_sel    = {1'b0, DUTY_FULL} - {1'b0, hold_reg};
            settle_duty = hold_reg;
        end else begin
            if (switch_mode_reg == MODE_ON || switch_mode_reg == MODE_TURNING_ON)
            begin
                mode_next      = MODE_TURNING_OFF;
                off_start_next = now_ms;
            end
            start_sel   = off_start_next;
            len_sel     = off_ramp_reg;
            lo_sel      = off_low_reg;
            span_sel    = {1'b0, off_high_reg} - {1'b0, off_low_reg};
            settle_duty = DUTY_ZERO;
        end
        elapsed = now_ms - start_sel;
        settle  = (func == FUNC_ON)  ? (mode_next == MODE_TURNING_ON)
                                     : (mode_next == MODE_TURNING_OFF);
        ramp_go = settle && (elapsed < {{(TIME_W-RAMP_W){1'b0}}, len_sel});
    end

    // ---------------------------------------------------------------
    // Shared compare/subtract step of the divider
    // ---------------------------------------------------------------
    logic                  div_fit;
    logic [DUTY_W-1:0]     quot_next;
    logic [DUTY_W-1:0]     ramp_duty;

    always_comb
    begin
        div_fit   = (prod_reg >= dvs_reg);
        quot_next = {quot_reg[DUTY_W-2:0], div_fit};
        ramp_duty = span_neg_reg ? (lo_reg - quot_next) : (lo_reg + quot_next);
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            on_ramp_reg  <= '0;
            off_ramp_reg <= '0;
            hold_reg     <= DUTY_FULL;
            off_low_reg  <= DUTY_ZERO;
            off_high_reg <= DUTY_FULL;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ON_RAMP:  on_ramp_reg  <= cfg_data;
                REG_OFF_RAMP: off_ramp_reg <= cfg_data;
                REG_HOLD:     hold_reg     <= cfg_data[DUTY_W-1:0];
                REG_OFF_LOW:  off_low_reg  <= cfg_data[DUTY_W-1:0];
                REG_OFF_HIGH: off_high_reg <= cfg_data[DUTY_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer, switch state and output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            switch_mode_reg <= MODE_OFF;
            on_start_reg    <= '0;
            off_start_reg   <= '0;
            duty_level_reg  <= DUTY_ZERO;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end else begin
            // Output valid: set when a result is posted, cleared once taken
            if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid) begin
                        on_start_reg  <= on_start_next;
                        off_start_reg <= off_start_next;
                        rem_reg       <= len_sel - elapsed[RAMP_W-1:0];
                        len_reg       <= len_sel;
                        lo_reg        <= lo_sel;
                        span_neg_reg  <= span_sel[DUTY_W];
                        span_mag_reg  <= span_sel[DUTY_W] ? -span_sel[DUTY_W-1:0]
                                                          : span_sel[DUTY_W-1:0];
                        if (ramp_go) begin
                            switch_mode_reg <= mode_next;
                            state_reg       <= ST_MUL;
                        end else begin
                            if (settle) begin
                                duty_level_reg  <= settle_duty;
                                switch_mode_reg <= (func == FUNC_ON) ? MODE_ON : MODE_OFF;
                            end
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(rem_reg) * PROD_W'(span_mag_reg);
                    dvs_reg   <= {1'b0, len_reg, 7'b0};
                    quot_reg  <= '0;
                    cnt_reg   <= 3'd7;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_fit)
                        prod_reg <= prod_reg - dvs_reg;
                    dvs_reg  <= dvs_reg >> 1;
                    quot_reg <= quot_next;
                    cnt_reg  <= cnt_reg - 3'd1;
                    if (cnt_reg == 3'd0) begin
                        duty_level_reg <= ramp_duty;
                        state_reg      <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || out_ready) begin
                        out_duty_reg  <= duty_level_reg;
                        out_mode_reg  <= switch_mode_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign duty      = out_duty_reg;
    assign mode      = out_mode_reg;

endmodule
